/* sv/wac_pkg.sv */
// Shared types, constants and helpers for the weekday alarm clock.
package wac_pkg;

  localparam logic [6:0] SEC_LIMIT  = 7'd60;
  localparam logic [6:0] HOUR_LIMIT = 7'd24;
  localparam logic [6:0] DAY_LIMIT  = 7'd7;
  localparam logic [6:0] BIG_STEP   = 7'd10;

  // field being set in the clock view
  typedef enum logic [2:0] {
    CF_HOUR,
    CF_MIN,
    CF_SEC,
    CF_DAY,
    CF_NONE
  } clock_field_t;

  // field being set in the alarm view
  typedef enum logic [1:0] {
    AF_HOUR,
    AF_MIN,
    AF_DAY,
    AF_NONE
  } alarm_field_t;

  // one input word
  typedef struct packed {
    logic cmd;    // 0 tick, 1 button sample
    logic adj;
    logic add;
    logic add10;
    logic sw;
  } item_t;

  typedef struct packed {
    logic [5:0]   sec;
    logic [5:0]   min;
    logic [4:0]   hour;
    logic [2:0]   day;
    logic [5:0]   a_min;
    logic [4:0]   a_hour;
    logic [2:0]   a_day;
    clock_field_t clock_mode;
    alarm_field_t alarm_mode;
    // press marks, clock view
    logic         cm_adj;
    logic         cm_add;
    logic         cm_add10;
    // press marks, alarm view
    logic         am_adj;
    logic         am_add;
    logic         am_add10;
    // view flags
    logic         clk_idle;
    logic         sw_mark;
    logic         aview;
    logic         a_idle;
    logic         exit_mark;
    // alarm flags
    logic         arm_en;
    logic         arm_mark;
    logic         armed;
    logic         dis_mark;
    logic         sil_mark;
    logic         ring;
    logic         buz;
  } state_t;

  function automatic logic [6:0] inc_wrap(logic [6:0] v, logic [6:0] lim);
    logic [6:0] t;
    t = v + 7'd1;
    return (t >= lim) ? 7'd0 : t;
  endfunction

  // add ten, clearing to zero at or past the limit
  function automatic logic [6:0] add_ten(logic [6:0] v, logic [6:0] lim);
    logic [6:0] t;
    t = v + BIG_STEP;
    return (t >= lim) ? 7'd0 : t;
  endfunction

endpackage

/* sv/weekday_alarm_clock.sv */
// Top level of the weekday alarm clock: input stage, state core, result register.
//
//   channel  | handshake           | word
//   ---------+---------------------+-------------------------------------------
//   in       | in_valid / in_ready | cmd, btn_adjust, btn_add, btn_add10,
//            |                     | btn_alarm
//   out      | out_valid/out_ready | seconds .. weekday, alarm setting, view,
//            |                     | set_field, armed, ringing, buzzer
//
// A word is held in the input stage until it is applied to the state; the
// result register loads the new state at the same edge that updates the state,
// and out_valid rises at that edge.
// One word per cycle sustained while out_ready is high: the state update is one pass of logic.
// rst (synchronous): time 00:00:00 Sunday, alarm 00:00 Sunday, clock view,
// no field being set, alarm disarmed, buzzer off.
// A stalled result holds the input stage; in_ready drops only when both the
// input stage and the result register are full and out_ready is low.
module weekday_alarm_clock (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd,
  input  logic       btn_adjust,
  input  logic       btn_add,
  input  logic       btn_add10,
  input  logic       btn_alarm,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] seconds,
  output logic [5:0] minutes,
  output logic [4:0] hours,
  output logic [2:0] weekday,
  output logic [5:0] alarm_minutes,
  output logic [4:0] alarm_hours,
  output logic [2:0] alarm_weekday,
  output logic       alarm_view,
  output logic [2:0] set_field,
  output logic       armed,
  output logic       ringing,
  output logic       buzzer
);
  import wac_pkg::*;

  logic   st_valid;   // input stage holds a word
  item_t  st_item;
  logic   step;       // apply staged word this cycle
  state_t state_next;
  state_t res;        // result register payload

  assign step     = st_valid && (!out_valid || out_ready);
  assign in_ready = !st_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_item <= '{cmd: cmd, adj: btn_adjust, add: btn_add, add10: btn_add10,
                   sw: btn_alarm};
    end
  end

  wac_clock_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (st_item),
    .state_next (state_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= state_next;
    end
  end

  assign seconds       = res.sec;
  assign minutes       = res.min;
  assign hours         = res.hour;
  assign weekday       = res.day;
  assign alarm_minutes = res.a_min;
  assign alarm_hours   = res.a_hour;
  assign alarm_weekday = res.a_day;
  assign alarm_view    = res.aview;
  assign set_field     = res.aview ? {1'b0, res.alarm_mode} : res.clock_mode;
  assign armed         = res.armed;
  assign ringing       = res.ring;
  assign buzzer        = res.buz;

`ifndef NO_ASSERTIONS
  a_ring_needs_arm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!ringing || armed))
    else $error("ringing while disarmed");

  a_buzz_needs_ring: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!buzzer || ringing))
    else $error("buzzer active while not ringing");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (seconds < 6'd60 && minutes < 6'd60 && hours < 5'd24 && weekday < 3'd7))
    else $error("clock field out of range");

  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("applied word did not reach the result register");

  a_field_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alarm_view ? (set_field <= 3'd3) : (set_field <= 3'd4)))
    else $error("set_field out of range for view");
`endif

endmodule

/* sv/wac_update.sv */
// Next-state logic for one tick or one button sample.
module wac_update (
  input  wac_pkg::state_t cur,
  input  wac_pkg::item_t  item,
  output wac_pkg::state_t nx
);
  import wac_pkg::*;

  always_comb begin
    nx = cur;
    if (!item.cmd) begin
      // one-second tick, carries ripple up to the weekday
      nx.sec = 6'(inc_wrap(7'(cur.sec), SEC_LIMIT));
      if (nx.sec == 6'd0) begin
        nx.min = 6'(inc_wrap(7'(cur.min), SEC_LIMIT));
        if (nx.min == 6'd0) begin
          nx.hour = 5'(inc_wrap(7'(cur.hour), HOUR_LIMIT));
          if (nx.hour == 5'd0) begin
            nx.day = 3'(inc_wrap(7'(cur.day), DAY_LIMIT));
          end
        end
      end
      if (cur.ring) begin
        nx.buz = !cur.buz;
      end
    end else begin
      // view switch
      if (nx.clk_idle) begin
        if (!item.sw) begin
          nx.sw_mark = 1'b1;
        end
        nx.alarm_mode = AF_HOUR;
      end
      if ((item.sw && nx.sw_mark) || nx.aview) begin
        nx.clk_idle = 1'b0;
        nx.sw_mark  = 1'b0;
        nx.aview    = 1'b1;
        // alarm setting
        if (!item.adj) begin
          nx.am_adj = 1'b1;
        end
        if (!item.add) begin
          nx.am_add = 1'b1;
        end
        if (!item.add10) begin
          nx.am_add10 = 1'b1;
        end
        if (item.adj && nx.am_adj) begin
          nx.am_adj     = 1'b0;
          nx.alarm_mode = (nx.alarm_mode == AF_NONE) ? AF_HOUR
                        : alarm_field_t'(nx.alarm_mode + 2'd1);
        end
        nx.a_idle = (nx.alarm_mode == AF_NONE);
        nx.arm_en = (nx.alarm_mode == AF_NONE);
        if (item.add && nx.am_add) begin
          nx.am_add = 1'b0;
          unique case (nx.alarm_mode)
            AF_HOUR: nx.a_hour = 5'(inc_wrap(7'(nx.a_hour), HOUR_LIMIT));
            AF_MIN:  nx.a_min  = 6'(inc_wrap(7'(nx.a_min), SEC_LIMIT));
            AF_DAY:  nx.a_day  = 3'(inc_wrap(7'(nx.a_day), DAY_LIMIT));
            AF_NONE: ;
          endcase
        end
        if (item.add10 && nx.am_add10) begin
          nx.am_add10 = 1'b0;
          unique case (nx.alarm_mode)
            AF_HOUR: nx.a_hour = 5'(add_ten(7'(nx.a_hour), HOUR_LIMIT));
            AF_MIN:  nx.a_min  = 6'(add_ten(7'(nx.a_min), SEC_LIMIT));
            AF_DAY, AF_NONE: ;
          endcase
        end
        if (nx.a_idle) begin
          if (!item.sw) begin
            nx.exit_mark = 1'b1;
          end
          if (item.sw && nx.exit_mark) begin
            nx.aview = 1'b0;
          end
        end
      end else begin
        nx.a_idle    = 1'b0;
        nx.exit_mark = 1'b0;
        // clock setting
        if (!item.adj) begin
          nx.cm_adj = 1'b1;
        end
        if (!item.add) begin
          nx.cm_add = 1'b1;
        end
        if (!item.add10) begin
          nx.cm_add10 = 1'b1;
        end
        if (item.adj && nx.cm_adj) begin
          nx.cm_adj     = 1'b0;
          nx.clock_mode = (nx.clock_mode == CF_NONE) ? CF_HOUR
                        : clock_field_t'(nx.clock_mode + 3'd1);
        end
        nx.clk_idle = (nx.clock_mode == CF_NONE);
        nx.arm_en   = (nx.clock_mode == CF_NONE);
        if (item.add && nx.cm_add) begin
          nx.cm_add = 1'b0;
          unique case (nx.clock_mode)
            CF_HOUR: nx.hour = 5'(inc_wrap(7'(nx.hour), HOUR_LIMIT));
            CF_MIN:  nx.min  = 6'(inc_wrap(7'(nx.min), SEC_LIMIT));
            CF_SEC:  nx.sec  = 6'(inc_wrap(7'(nx.sec), SEC_LIMIT));
            CF_DAY:  nx.day  = 3'(inc_wrap(7'(nx.day), DAY_LIMIT));
            default: ;
          endcase
        end
        if (item.add10 && nx.cm_add10) begin
          nx.cm_add10 = 1'b0;
          unique case (nx.clock_mode)
            CF_HOUR: nx.hour = 5'(add_ten(7'(nx.hour), HOUR_LIMIT));
            CF_MIN:  nx.min  = 6'(add_ten(7'(nx.min), SEC_LIMIT));
            CF_SEC:  nx.sec  = 6'(add_ten(7'(nx.sec), SEC_LIMIT));
            default: ;
          endcase
        end
      end

      // arm, disarm, silence; only with no field being set
      if (nx.arm_en) begin
        if (!item.add10) begin
          nx.arm_mark = 1'b1;
        end
        if (nx.ring) begin
          if (!item.add) begin
            nx.sil_mark = 1'b1;
          end
          if (item.add && nx.sil_mark) begin
            nx.sil_mark = 1'b0;
            nx.ring     = 1'b0;
            nx.buz      = 1'b0;
            nx.dis_mark = 1'b1;   // silencing also sets the disarm mark; armed stays set
          end
        end
        if ((item.add10 && nx.arm_mark) || nx.armed) begin
          nx.armed = 1'b1;
          if (nx.hour == nx.a_hour && nx.min == nx.a_min && nx.day == nx.a_day) begin
            nx.ring = 1'b1;
          end
          if (!item.add10) begin
            nx.dis_mark = 1'b1;
          end
          if (item.add10 && nx.dis_mark) begin
            nx.dis_mark = 1'b0;
            nx.armed    = 1'b0;
            nx.arm_mark = 1'b0;
            nx.ring     = 1'b0;
            nx.buz      = 1'b0;
          end
        end
      end
    end
  end

endmodule

/* sv/wac_clock_core.sv */
// Clock and alarm state register with its combinational next-state update.
module wac_clock_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  wac_pkg::item_t  item,
  output wac_pkg::state_t state_next
);
  import wac_pkg::*;

  // time 00:00:00 Sunday, clock view with no field selected, alarm field at hour, everything else clear
  localparam state_t STATE_RESET = '{clock_mode: CF_NONE, alarm_mode: AF_HOUR, default: '0};

  state_t state;

  wac_update u_update (
    .cur  (state),
    .item (item),
    .nx   (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule
